[rtl/postfix_to_three_address_emitter_assert.svh]
// assertion macros used by the checker file
// clk_i and rst_ni must be visible where these are used
`ifndef POSTFIX_TO_THREE_ADDRESS_EMITTER_ASSERT_SVH
`define POSTFIX_TO_THREE_ADDRESS_EMITTER_ASSERT_SVH

// property that must hold in the same cycle
`define P2TAC_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication checked in the following cycle
`define P2TAC_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/p2tac_pkg.sv]
`default_nettype none

package p2tac_pkg;

  typedef enum logic [2:0] {
    MODE_END   = 3'd0,
    MODE_IDENT = 3'd1,
    MODE_LIT   = 3'd2,
    MODE_DEREF = 3'd3,
    MODE_ADD   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    KIND_LITERAL  = 2'd0,
    KIND_TEMP     = 2'd1,
    KIND_VARIABLE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REC_LOAD  = 2'd0,
    REC_ADD   = 2'd1,
    REC_END   = 2'd2,
    REC_ERROR = 2'd3
  } record_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_OVERFLOW  = 2'd1,
    ERR_UNDERFLOW = 2'd2,
    ERR_OPCODE    = 2'd3
  } err_e;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] value;
  } ref_t;

  typedef struct packed {
    record_e     record_kind;
    err_e        error_code;
    ref_t        left;
    ref_t        right;
    logic [31:0] dest_temp;
    logic [4:0]  depth;
  } result_t;

endpackage

`default_nettype wire

[rtl/p2tac_spill.sv]
`default_nettype none

// spill store for stack entries below the two cached top entries
module p2tac_spill #(
  parameter int unsigned DEPTH = 16
) (
  input  wire                        clk_i,
  input  wire                        wr_en_i,
  input  wire  [$clog2(DEPTH)-1:0]   wr_addr_i,
  input  p2tac_pkg::ref_t            wr_data_i,
  input  wire  [$clog2(DEPTH)-1:0]   rd_addr_i,
  output p2tac_pkg::ref_t            rd_data_o
);
  import p2tac_pkg::*;

  ref_t mem [DEPTH];
  ref_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read, forwarding a write to the same entry
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
      rd_q <= wr_data_i;
    end else begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

[rtl/postfix_to_three_address_emitter.sv]
// latency: a result is valid on the cycle after its input transfer
// throughput: one input item per cycle; the only hold-off is a stalled full result register
// reset: stack emptied, temporary counter set to 1, no result pending
// the stack storage itself is not cleared; only entries pushed since the last clear are read
`default_nettype none

module postfix_to_three_address_emitter #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // input channel
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  wire  [2:0]  mode_i,
  input  wire  [63:0] operand_i,
  // result channel
  output logic        out_valid_o,
  input  wire         out_stall_i,
  output logic [1:0]  record_kind_o,
  output logic [1:0]  error_code_o,
  output logic [1:0]  left_kind_o,
  output logic [63:0] left_value_o,
  output logic [1:0]  right_kind_o,
  output logic [63:0] right_value_o,
  output logic [31:0] dest_temp_o,
  output logic [4:0]  depth_o
);
  import p2tac_pkg::*;

  localparam int unsigned CntW  = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(STACK_DEPTH);

  // stack organization:
  //   tos_q  entry count-1 (top), nos_q entry count-2
  //   spill store holds entries 0 .. count-3 at their own index
  //   bot_q  mirrors entry 0 so an end item never needs a store read
  //   spill_rdata holds entry count-3 whenever count is at least 3, ready for the next add
  logic [CntW-1:0] count_q, count_d;
  logic [31:0]     temp_q, temp_d;
  ref_t            tos_q, tos_d;
  ref_t            nos_q, nos_d;
  ref_t            bot_q, bot_d;

  logic             spill_we;
  logic [AddrW-1:0] spill_waddr;
  logic [AddrW-1:0] spill_raddr;
  ref_t             spill_rdata;

  logic    accept;
  logic    res_valid;
  result_t res;
  ref_t    push_ref;
  ref_t    temp_ref;
  ref_t    bottom_ref;

  logic    out_valid_q;
  result_t out_q;

  // a transfer is blocked only while a finished result sits stalled
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign push_ref.kind  = (mode_i == MODE_IDENT) ? KIND_VARIABLE : KIND_LITERAL;
  assign push_ref.value = operand_i;
  assign temp_ref.kind  = KIND_TEMP;
  assign temp_ref.value = 64'(temp_q);

  // entry 0 lives in the cache registers while the stack is shallow
  assign bottom_ref = (count_q == CntW'(1)) ? tos_q :
                      (count_q == CntW'(2)) ? nos_q : bot_q;

  always_comb begin
    count_d     = count_q;
    temp_d      = temp_q;
    tos_d       = tos_q;
    nos_d       = nos_q;
    bot_d       = bot_q;
    spill_we    = 1'b0;
    spill_waddr = AddrW'(count_q - CntW'(2));
    res_valid   = 1'b0;
    res         = '0;

    if (accept) begin
      case (mode_i)
        MODE_END: begin
          res_valid       = 1'b1;
          res.record_kind = REC_END;
          if (count_q != '0) begin
            res.left = bottom_ref;
          end
          res.depth = 5'(count_q);
          count_d   = '0;
        end
        MODE_IDENT, MODE_LIT: begin
          if (count_q >= CntW'(STACK_DEPTH)) begin
            res_valid       = 1'b1;
            res.record_kind = REC_ERROR;
            res.error_code  = ERR_OVERFLOW;
            count_d         = '0;
          end else begin
            // old second entry spills once there are two below the new top
            spill_we = (count_q >= CntW'(2));
            tos_d    = push_ref;
            nos_d    = tos_q;
            if (count_q == '0) begin
              bot_d = push_ref;
            end
            count_d = count_q + CntW'(1);
          end
        end
        MODE_DEREF: begin
          res_valid = 1'b1;
          if (count_q == '0) begin
            res.record_kind = REC_ERROR;
            res.error_code  = ERR_UNDERFLOW;
            count_d         = '0;
          end else begin
            res.record_kind = REC_LOAD;
            res.left        = tos_q;
            res.dest_temp   = temp_q;
            tos_d           = temp_ref;
            temp_d          = temp_q + 32'd1;
            if (count_q == CntW'(1)) begin
              bot_d = temp_ref;
            end
          end
        end
        MODE_ADD: begin
          res_valid = 1'b1;
          if (count_q < CntW'(2)) begin
            res.record_kind = REC_ERROR;
            res.error_code  = ERR_UNDERFLOW;
            count_d         = '0;
          end else begin
            res.record_kind = REC_ADD;
            res.left        = nos_q;
            res.right       = tos_q;
            res.dest_temp   = temp_q;
            tos_d           = temp_ref;
            // refill the second slot from the prefetched spill entry
            nos_d           = spill_rdata;
            temp_d          = temp_q + 32'd1;
            if (count_q == CntW'(2)) begin
              bot_d = temp_ref;
            end
            count_d = count_q - CntW'(1);
          end
        end
        default: begin
          res_valid       = 1'b1;
          res.record_kind = REC_ERROR;
          res.error_code  = ERR_OPCODE;
          count_d         = '0;
        end
      endcase
    end
  end

  // prefetch entry count-3 of the next state
  assign spill_raddr = AddrW'(count_d - CntW'(3));

  p2tac_spill #(
    .DEPTH(STACK_DEPTH)
  ) u_spill (
    .clk_i     (clk_i),
    .wr_en_i   (spill_we),
    .wr_addr_i (spill_waddr),
    .wr_data_i (nos_q),
    .rd_addr_i (spill_raddr),
    .rd_data_o (spill_rdata)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      temp_q  <= 32'd1;
    end else begin
      count_q <= count_d;
      temp_q  <= temp_d;
    end
  end

  // cached stack entries, no reset needed
  always_ff @(posedge clk_i) begin
    tos_q <= tos_d;
    nos_q <= nos_d;
    bot_q <= bot_d;
  end

  // result register: loads whenever empty or being drained
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign record_kind_o = out_q.record_kind;
  assign error_code_o  = out_q.error_code;
  assign left_kind_o   = out_q.left.kind;
  assign left_value_o  = out_q.left.value;
  assign right_kind_o  = out_q.right.kind;
  assign right_value_o = out_q.right.value;
  assign dest_temp_o   = out_q.dest_temp;
  assign depth_o       = out_q.depth;

endmodule

`default_nettype wire

[rtl/p2tac_checker.sv]
`default_nettype none

`include "postfix_to_three_address_emitter_assert.svh"

module p2tac_checker (
  input wire        clk_i,
  input wire        rst_ni,
  input wire        out_valid_o,
  input wire        out_stall_i,
  input wire [1:0]  record_kind_o,
  input wire [1:0]  error_code_o,
  input wire [1:0]  left_kind_o,
  input wire [63:0] left_value_o,
  input wire [1:0]  right_kind_o,
  input wire [63:0] right_value_o,
  input wire [31:0] dest_temp_o,
  input wire [4:0]  depth_o
);
  import p2tac_pkg::*;

  logic        seen_q;
  logic [31:0] last_dest_q;
  logic        out_xfer;
  logic        is_temp_rec;

  assign out_xfer    = out_valid_o && !out_stall_i;
  assign is_temp_rec = (record_kind_o == REC_LOAD) || (record_kind_o == REC_ADD);

  // last temporary number handed out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q      <= 1'b0;
      last_dest_q <= '0;
    end else if (out_xfer && is_temp_rec) begin
      seen_q      <= 1'b1;
      last_dest_q <= dest_temp_o;
    end
  end

  `P2TAC_ASSERT_NEXT(a_stall_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(record_kind_o) && $stable(left_value_o) &&
    $stable(right_value_o) && $stable(dest_temp_o),
    "result changed while stalled")
  `P2TAC_ASSERT(a_temp_sequence, !(out_valid_o && is_temp_rec) ||
    (dest_temp_o == (seen_q ? last_dest_q + 32'd1 : 32'd1)),
    "temporary numbers not consecutive")
  `P2TAC_ASSERT(a_error_clean, !(out_valid_o && record_kind_o == REC_ERROR) ||
    (error_code_o != ERR_NONE && left_kind_o == '0 && left_value_o == '0 &&
    right_kind_o == '0 && right_value_o == '0 && dest_temp_o == '0 && depth_o == '0),
    "error record carries data")
  `P2TAC_ASSERT(a_end_empty, !(out_valid_o && record_kind_o == REC_END && depth_o == '0) ||
    (left_kind_o == '0 && left_value_o == '0 && error_code_o == ERR_NONE),
    "empty end record carries data")

endmodule

bind postfix_to_three_address_emitter p2tac_checker u_p2tac_checker (.*);

`default_nettype wire
